FILE: design/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/mptpc_pkg.sv
`timescale 1ns / 1ps

package mptpc_pkg;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_COARSE   = 5'b00010,
		PH_SETTLE   = 5'b00100,
		PH_FINE_ON  = 5'b01000,
		PH_FINE_OFF = 5'b10000
	} phase_t;

	typedef enum logic [3:0] {
		CT_IDLE = 4'b0001,
		CT_SUB  = 4'b0010,
		CT_MUL  = 4'b0100,
		CT_FIN  = 4'b1000
	} ctl_t;

	localparam logic [1:0] REG_KP_GAIN     = 2'd0;
	localparam logic [1:0] REG_DRIVE_SCALE = 2'd1;
	localparam logic [1:0] REG_MIN_SPEED   = 2'd2;

	localparam logic [15:0] KP_GAIN_RST     = 16'd256;
	localparam logic [7:0]  DRIVE_SCALE_RST = 8'd1;
	localparam logic [7:0]  MIN_SPEED_RST   = 8'd40;

	localparam logic [7:0] COARSE_LIMIT = 8'd4;
	localparam logic [7:0] FINE_LIMIT   = 8'd5;
	localparam logic [7:0] SETTLE_TICKS = 8'd50;
	localparam logic [7:0] PULSE_TICKS  = 8'd10;
	localparam logic [7:0] REST_TICKS   = 8'd250;
	localparam logic [7:0] PULSE_DUTY   = 8'd50;
	localparam logic [7:0] DUTY_MAX     = 8'd255;

	localparam int KP_W = 16;

endpackage

FILE: design/motor_position_two_phase_controller.sv
`timescale 1ns / 1ps
// Two-phase proportional position controller. A word with mode 1 latches a new
// target and answers from the CT_FIN state once the output is not stalled. A
// word with mode 0 is a tick carrying the encoder count; a bit-serial subtractor
// forms the position error in CT_SUB, a serial-parallel multiplier scales its
// magnitude by kp_gain in CT_MUL, and the answer leaves from CT_FIN. One word
// is worked on at a time; a new word is taken while the previous result still
// waits at the output.
`include "assert_macros.svh"

module motor_position_two_phase_controller
	import mptpc_pkg::*;
#(
	parameter int POS_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic signed [POS_WIDTH-1:0] target,
	input  logic signed [POS_WIDTH-1:0] position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  pwm_duty,
	output logic                        direction,
	output logic                        busy_res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int SUB_LAST = POS_WIDTH;
	localparam int MUL_LAST = POS_WIDTH + KP_W;
	localparam int CW       = $clog2(MUL_LAST + 1);

	logic [15:0] kp_gain_q;
	logic [7:0]  drive_scale_q;
	logic [7:0]  min_speed_q;

	ctl_t                        ctl_q;
	logic [CW-1:0]               cnt_q;
	logic                        mode_q;
	phase_t                      phase_q;
	logic signed [POS_WIDTH-1:0] target_hold_q;
	logic [7:0]                  tick_timer_q;
	logic                        dir_hold_q;
	logic [7:0]                  duty_hold_q;

	logic                 out_valid_q;
	logic [7:0]           pwm_duty_q;
	logic                 direction_q;
	logic                 busy_res_q;

	logic [POS_WIDTH-1:0] tgt_sh_q;
	logic [POS_WIDTH-1:0] pos_sh_q;
	logic [POS_WIDTH:0]   err_sh_q;
	logic                 carry_q;
	logic                 nz_q;
	logic                 seen_q;
	logic [KP_W-1:0]      acc_q;
	logic [7:0]           corr_q;
	logic                 sat_q;

	logic cfg_wr;
	logic in_acc;
	logic fin_go;

	logic            sub_a;
	logic            sub_b;
	logic            sub_d;
	logic            sub_c;
	logic            mul_bit;
	logic [KP_W-1:0] mul_pp;
	logic [KP_W:0]   mul_sum;

	logic        gt_coarse;
	logic        gt_fine;
	logic [15:0] prod;
	logic [7:0]  duty_raw;
	logic [7:0]  duty_coarse;
	logic        dir_eval;
	logic [7:0]  tick_dec;

	phase_t     ph_n;
	logic [7:0] tm_n;
	logic [7:0] duty_n;
	logic       dir_n;

	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign in_stall  = (ctl_q != CT_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign fin_go    = (ctl_q == CT_FIN) & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign pwm_duty  = pwm_duty_q;
	assign direction = direction_q;
	assign busy_res  = busy_res_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_KP_GAIN:     prdata = {16'd0, kp_gain_q};
			REG_DRIVE_SCALE: prdata = {24'd0, drive_scale_q};
			REG_MIN_SPEED:   prdata = {24'd0, min_speed_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_gain_q     <= KP_GAIN_RST;
			drive_scale_q <= DRIVE_SCALE_RST;
			min_speed_q   <= MIN_SPEED_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_KP_GAIN:     kp_gain_q     <= pwdata[15:0];
				REG_DRIVE_SCALE: drive_scale_q <= pwdata[7:0];
				REG_MIN_SPEED:   min_speed_q   <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	// The error target_hold - position is formed LSB first as a + ~b + 1.
	assign sub_a = tgt_sh_q[0];
	assign sub_b = ~pos_sh_q[0];
	assign sub_d = sub_a ^ sub_b ^ carry_q;
	assign sub_c = (sub_a & sub_b) | (sub_a & carry_q) | (sub_b & carry_q);

	// A negative error is negated on the fly: bits flip after the first one.
	assign mul_bit = err_sh_q[0] ^ (err_sh_q[POS_WIDTH] & seen_q);
	assign mul_pp  = mul_bit ? kp_gain_q : '0;
	assign mul_sum = {1'b0, acc_q} + {1'b0, mul_pp};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tgt_sh_q <= target_hold_q;
			pos_sh_q <= position;
			carry_q  <= 1'b1;
			nz_q     <= 1'b0;
		end else if (ctl_q == CT_SUB) begin
			tgt_sh_q <= {tgt_sh_q[POS_WIDTH-1], tgt_sh_q[POS_WIDTH-1:1]};
			pos_sh_q <= {pos_sh_q[POS_WIDTH-1], pos_sh_q[POS_WIDTH-1:1]};
			err_sh_q <= {sub_d, err_sh_q[POS_WIDTH:1]};
			carry_q  <= sub_c;
			nz_q     <= nz_q | sub_d;
			acc_q    <= '0;
			seen_q   <= 1'b0;
			corr_q   <= '0;
			sat_q    <= 1'b0;
		end else if (ctl_q == CT_MUL) begin
			err_sh_q <= {err_sh_q[POS_WIDTH], err_sh_q[POS_WIDTH:1]};
			seen_q   <= seen_q | err_sh_q[0];
			acc_q    <= mul_sum[KP_W:1];
			if ((cnt_q >= CW'(8)) && (cnt_q < CW'(16))) begin
				corr_q <= {mul_sum[0], corr_q[7:1]};
			end
			if ((cnt_q >= CW'(16)) && mul_sum[0]) begin
				sat_q <= 1'b1;
			end
		end
	end

	assign gt_coarse = sat_q | (corr_q > COARSE_LIMIT);
	assign gt_fine   = sat_q | (corr_q > FINE_LIMIT);
	assign prod      = 16'(corr_q) * 16'(drive_scale_q);

	always_comb begin
		if (sat_q) begin
			duty_raw = (drive_scale_q != 8'd0) ? DUTY_MAX : 8'd0;
		end else if (prod > 16'(DUTY_MAX)) begin
			duty_raw = DUTY_MAX;
		end else begin
			duty_raw = prod[7:0];
		end
	end

	assign duty_coarse = (duty_raw < min_speed_q) ? min_speed_q : duty_raw;
	assign dir_eval    = err_sh_q[POS_WIDTH] ? 1'b0 : (nz_q ? 1'b1 : dir_hold_q);
	assign tick_dec    = (tick_timer_q != 8'd0) ? (tick_timer_q - 8'd1) : 8'd0;

	always_comb begin
		ph_n   = phase_q;
		tm_n   = tick_timer_q;
		duty_n = duty_hold_q;
		dir_n  = dir_hold_q;
		if (mode_q) begin
			ph_n   = PH_COARSE;
			tm_n   = 8'd0;
			duty_n = 8'd0;
		end else begin
			unique case (phase_q)
				PH_COARSE: begin
					dir_n = dir_eval;
					if (gt_coarse) begin
						duty_n = duty_coarse;
					end else begin
						duty_n = 8'd0;
						ph_n   = PH_SETTLE;
						tm_n   = SETTLE_TICKS;
					end
				end
				PH_SETTLE, PH_FINE_OFF: begin
					duty_n = 8'd0;
					tm_n   = tick_dec;
					if (tick_dec == 8'd0) begin
						dir_n = dir_eval;
						if (gt_fine) begin
							ph_n   = PH_FINE_ON;
							tm_n   = PULSE_TICKS;
							duty_n = PULSE_DUTY;
						end else begin
							ph_n = PH_IDLE;
						end
					end
				end
				PH_FINE_ON: begin
					tm_n = tick_dec;
					if (tick_dec == 8'd0) begin
						duty_n = 8'd0;
						ph_n   = PH_FINE_OFF;
						tm_n   = REST_TICKS;
					end else begin
						duty_n = PULSE_DUTY;
					end
				end
				default: begin
					ph_n   = PH_IDLE;
					tm_n   = 8'd0;
					duty_n = 8'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q         <= CT_IDLE;
			cnt_q         <= '0;
			mode_q        <= 1'b0;
			phase_q       <= PH_IDLE;
			target_hold_q <= '0;
			tick_timer_q  <= '0;
			dir_hold_q    <= 1'b0;
			duty_hold_q   <= '0;
			out_valid_q   <= 1'b0;
			pwm_duty_q    <= '0;
			direction_q   <= 1'b0;
			busy_res_q    <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctl_q)
				CT_IDLE: begin
					if (in_acc) begin
						mode_q <= mode;
						cnt_q  <= '0;
						if (mode) begin
							target_hold_q <= target;
							ctl_q         <= CT_FIN;
						end else begin
							ctl_q <= CT_SUB;
						end
					end
				end
				CT_SUB: begin
					if (cnt_q == CW'(SUB_LAST)) begin
						cnt_q <= '0;
						ctl_q <= CT_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				CT_MUL: begin
					if (cnt_q == CW'(MUL_LAST)) begin
						cnt_q <= '0;
						ctl_q <= CT_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				CT_FIN: begin
					if (fin_go) begin
						phase_q      <= ph_n;
						tick_timer_q <= tm_n;
						duty_hold_q  <= duty_n;
						dir_hold_q   <= dir_n;
						out_valid_q  <= 1'b1;
						pwm_duty_q   <= duty_n;
						direction_q  <= dir_n;
						busy_res_q   <= (ph_n != PH_IDLE);
						ctl_q        <= CT_IDLE;
					end
				end
				default: ctl_q <= CT_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, ctl_q != CT_IDLE)
	`ASSERT_IMPL(a_idle_off, out_valid && !busy_res, pwm_duty == 8'd0)
	`ASSERT_IMPL(a_cnt_range, ctl_q == CT_MUL, cnt_q <= CW'(MUL_LAST))
	`ASSERT_NEXT(a_fin_delivers, fin_go, out_valid && ctl_q == CT_IDLE)

endmodule

FILE: tb/tb_motor_position_two_phase_controller.sv
`timescale 1ns / 1ps

module tb_motor_position_two_phase_controller
	import mptpc_pkg::*;
;

	localparam int POS_W = 24;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int END_WAIT = 200;

	typedef struct packed {
		logic [7:0] duty;
		logic       dir;
		logic       busy;
	} drive_t;

	class drive_predictor;
		logic [15:0] gain;
		logic [7:0]  scale;
		logic [7:0]  floor_duty;
		phase_t      stage;
		longint      goal;
		int unsigned ticks_left;
		logic        heading;
		logic [7:0]  duty_now;
		drive_t      expected_drive[$];
		int          mismatches;

		function new();
			gain = KP_GAIN_RST;
			scale = DRIVE_SCALE_RST;
			floor_duty = MIN_SPEED_RST;
			stage = PH_IDLE;
			goal = 0;
			ticks_left = 0;
			heading = 1'b0;
			duty_now = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_KP_GAIN: gain = val[15:0];
				REG_DRIVE_SCALE: scale = val[7:0];
				REG_MIN_SPEED: floor_duty = val[7:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] read_reg(logic [1:0] idx);
			case (idx)
				REG_KP_GAIN: return {16'd0, gain};
				REG_DRIVE_SCALE: return {24'd0, scale};
				REG_MIN_SPEED: return {24'd0, floor_duty};
				default: return 32'd0;
			endcase
		endfunction

		// The sign of the error steers the heading; a zero error keeps it.
		function longint unsigned correction(longint pos);
			longint err;
			longint unsigned mag;
			err = goal - pos;
			mag = 0;
			if (err > 0) begin
				heading = 1'b1;
				mag = err;
			end else if (err < 0) begin
				heading = 1'b0;
				mag = -err;
			end
			return (mag * gain) >> 8;
		endfunction

		function void fine_check(longint pos);
			if (correction(pos) > FINE_LIMIT) begin
				stage = PH_FINE_ON;
				ticks_left = PULSE_TICKS;
				duty_now = PULSE_DUTY;
			end else begin
				stage = PH_IDLE;
				ticks_left = 0;
				duty_now = '0;
			end
		endfunction

		function void note_word(logic m, logic signed [POS_W-1:0] t,
				logic signed [POS_W-1:0] p);
			longint pos;
			longint unsigned c;
			longint unsigned d;
			pos = p;
			if (m) begin
				goal = t;
				stage = PH_COARSE;
				ticks_left = 0;
				duty_now = '0;
			end else begin
				case (stage)
					PH_COARSE: begin
						c = correction(pos);
						if (c > COARSE_LIMIT) begin
							d = c * scale;
							if (d < floor_duty)
								d = floor_duty;
							if (d > DUTY_MAX)
								d = DUTY_MAX;
							duty_now = d[7:0];
						end else begin
							duty_now = '0;
							stage = PH_SETTLE;
							ticks_left = SETTLE_TICKS;
						end
					end
					PH_SETTLE, PH_FINE_OFF: begin
						duty_now = '0;
						if (ticks_left > 0)
							ticks_left--;
						if (ticks_left == 0)
							fine_check(pos);
					end
					PH_FINE_ON: begin
						if (ticks_left > 0)
							ticks_left--;
						if (ticks_left == 0) begin
							duty_now = '0;
							stage = PH_FINE_OFF;
							ticks_left = REST_TICKS;
						end else begin
							duty_now = PULSE_DUTY;
						end
					end
					default: begin
						stage = PH_IDLE;
						ticks_left = 0;
						duty_now = '0;
					end
				endcase
			end
			expected_drive.push_back(drive_t'{duty_now, heading, stage != PH_IDLE});
		endfunction

		task report(string msg);
			if (mismatches < 50)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_drive(logic [7:0] duty_in, logic dir_in, logic busy_in);
			drive_t want;
			if (expected_drive.size() == 0) begin
				report($sformatf("unexpected word duty %0d dir %0b busy %0b",
					duty_in, dir_in, busy_in));
				return;
			end
			want = expected_drive.pop_front();
			if (duty_in !== want.duty)
				report($sformatf("pwm_duty got %0d want %0d", duty_in, want.duty));
			if (dir_in !== want.dir)
				report($sformatf("direction got %0b want %0b", dir_in, want.dir));
			if (busy_in !== want.busy)
				report($sformatf("busy_res got %0b want %0b", busy_in, want.busy));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    mode = 1'b0;
	logic signed [POS_W-1:0] target = '0;
	logic signed [POS_W-1:0] position = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [7:0]              pwm_duty;
	logic                    direction;
	logic                    busy_res;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [3:0]              paddr = '0;
	logic [31:0]             pwdata = '0;
	logic [31:0]             prdata;
	logic                    pready;

	drive_predictor sb;
	int burst_left = 0;
	int words_sent = 0;
	int quiet = 0;

	motor_position_two_phase_controller #(
		.POS_WIDTH(POS_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.target   (target),
		.position (position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pwm_duty (pwm_duty),
		.direction(direction),
		.busy_res (busy_res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin : stall_gen
		int stall_kind;
		int len;
		int k;
		k = 0;
		forever begin
			stall_kind = $urandom_range(0, 3);
			len = $urandom_range(10, 200);
			repeat (len) begin
				@(posedge clk);
				k++;
				case (stall_kind)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (k % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_drive(pwm_duty, direction, busy_res);
		if (!arst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic reg_access(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_reg(idx, val);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd !== sb.read_reg(idx))
			sb.report($sformatf("register %0d reads %0h want %0h", idx, rd,
				sb.read_reg(idx)));
	endtask

	task automatic configure(input logic [15:0] g, input logic [7:0] s, input logic [7:0] f);
		logic [31:0] junk;
		junk = $urandom;
		reg_access(REG_KP_GAIN, {junk[31:16], g});
		reg_access(REG_DRIVE_SCALE, {junk[31:8], s});
		reg_access(REG_MIN_SPEED, {junk[31:8], f});
	endtask

	task automatic send_word(input logic m, input longint t, input longint p);
		logic signed [POS_W-1:0] tv;
		logic signed [POS_W-1:0] pv;
		int gap;
		tv = t[POS_W-1:0];
		pv = p[POS_W-1:0];
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			else if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(13, 30);
			else
				gap = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= m;
		target <= tv;
		position <= pv;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_word(m, tv, pv);
		burst_left--;
		words_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.expected_drive.size() != 0);
	endtask

	// A move, then ticks whose positions close in on the target; at each fine
	// check the offset is chosen to start a pulse or to end the move.
	task automatic run_move(input int max_ticks, input int pulses);
		logic signed [POS_W-1:0] r;
		longint goal;
		longint err;
		int n;
		r = POS_W'($urandom);
		if ($urandom_range(0, 1) == 0)
			goal = r;
		else
			goal = longint'($urandom_range(0, 2000)) - 1000;
		case ($urandom_range(0, 3))
			0: err = $urandom_range(0, 20);
			1: err = $urandom_range(0, 3000);
			2: err = $urandom_range(0, 200000);
			default: err = $urandom_range(0, 8388607);
		endcase
		if ($urandom_range(0, 1) == 1)
			err = -err;
		send_word(1'b1, goal, $urandom);
		n = 0;
		while (n < max_ticks && sb.stage != PH_IDLE) begin
			if (sb.stage == PH_COARSE) begin
				if ($urandom_range(0, 7) == 0)
					err = -err / 2;
				else
					err = err * longint'($urandom_range(0, 3)) / 4;
			end else if ((sb.stage == PH_SETTLE || sb.stage == PH_FINE_OFF)
					&& sb.ticks_left == 1) begin
				if (pulses > 0) begin
					err = $urandom_range(2000, 5000);
					pulses--;
				end else if (sb.gain <= KP_GAIN_RST) begin
					err = $urandom_range(0, 5);
				end else begin
					err = 0;
				end
				if ($urandom_range(0, 1) == 1)
					err = -err;
			end else begin
				err = longint'($urandom_range(0, 40)) - 20;
			end
			send_word(1'b0, $urandom, goal - err);
			n++;
		end
	endtask

	task automatic run_phase(input int budget, input bit with_pulse);
		int start;
		start = words_sent;
		if (with_pulse)
			run_move(400, 1);
		while (words_sent - start < budget) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_word(1'($urandom_range(0, 1)), $urandom, $urandom);
			end else begin
				run_move($urandom_range(5, 90), $urandom_range(0, 1));
			end
		end
		wait_idle();
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(KP_GAIN_RST, DRIVE_SCALE_RST, MIN_SPEED_RST);
		send_word(1'b0, 8388607, 0);
		send_word(1'b1, 8388607, -8388608);
		send_word(1'b0, -8388608, -8388608);
		send_word(1'b0, 0, 8388602);
		send_word(1'b0, 0, 8388607);
		send_word(1'b0, 0, 8388603);
		send_word(1'b1, -8388608, 8388607);
		send_word(1'b0, 8388607, 8388607);
		send_word(1'b0, 0, -8388604);
		send_word(1'b0, 0, -8388600);
		send_word(1'b1, 0, 0);
		send_word(1'b0, -1, 0);
		send_word(1'b1, -1, 8388607);
		send_word(1'b0, 0, -6);
		send_word(1'b0, 0, -5);
		send_word(1'b0, 0, -4);
		wait_idle();

		run_phase(320, 1'b1);
		configure(16'hFFFF, 8'hFF, 8'hFF);
		run_phase(90, 1'b0);
		configure(16'h0000, 8'h00, 8'h00);
		run_phase(60, 1'b0);
		configure(16'h0001, 8'h02, 8'h00);
		run_phase(90, 1'b0);
		configure(16'h0180, 8'h03, 8'h14);
		run_phase(90, 1'b0);
		configure(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		run_phase(90, 1'b0);

		repeat (END_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_drive.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/mptpc_pkg.sv
design/motor_position_two_phase_controller.sv
tb/tb_motor_position_two_phase_controller.sv
